/* rtl/sse_pkg.sv */
package sse_pkg;

	// Display geometry
	localparam int DIGIT_COUNT = 4;
	localparam int CHAR_FIELDS = 4;
	localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	// Beats per request: data-write, address, one per digit, display control
	localparam int BEAT_COUNT = DIGIT_COUNT + 3;
	localparam int BEAT_W     = $clog2(BEAT_COUNT);

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [BEAT_W-1:0] beat_t;

	localparam beat_t BEAT_DATA_CMD  = BEAT_W'(0);
	localparam beat_t BEAT_ADDR_CMD  = BEAT_W'(1);
	localparam beat_t BEAT_SEG_FIRST = BEAT_W'(2);
	localparam beat_t BEAT_SEG_LAST  = BEAT_W'(DIGIT_COUNT + 1);
	localparam beat_t BEAT_CTRL_CMD  = BEAT_W'(DIGIT_COUNT + 2);

	// Request kinds
	localparam logic REQ_NUMBER = 1'b0;
	localparam logic REQ_CHARS  = 1'b1;

	// Controller command bytes
	localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
	localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
	localparam logic [2:0] BRIGHT_RESET   = 3'd7;
	localparam logic [7:0] SEG_BLANK      = 8'h00;

	// Work carried down the digit pipeline
	typedef struct packed {
		logic                          cmd;
		logic [15:0]                   quot;
		logic [DIGIT_COUNT-1:0][7:0]   chars;
		logic [DIGIT_COUNT-1:0][7:0]   segs;
	} work_t;

	function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7d;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] seg_of_char(input logic [7:0] c);
		logic [7:0] s;
		if (c inside {[8'h30:8'h39]}) begin
			s = seg_of_digit(c[3:0]);
		end else begin
			s = SEG_BLANK;
		end
		return s;
	endfunction

	// Divide by ten through the reciprocal 52429 / 2^19, exact for 16-bit values
	function automatic logic [15:0] div10(input logic [15:0] x);
		logic [31:0] prod;
		prod = 32'(x) * 32'd52429;
		return 16'(prod[31:19]);
	endfunction

endpackage

/* rtl/sse_req_if.sv */
interface sse_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] number;
	logic [7:0]  char_first;
	logic [7:0]  char_second;
	logic [7:0]  char_third;
	logic [7:0]  char_fourth;

	modport source (
		output valid, cmd, number, char_first, char_second, char_third, char_fourth,
		input  ready
	);
	modport sink (
		input  valid, cmd, number, char_first, char_second, char_third, char_fourth,
		output ready
	);
endinterface

/* rtl/sse_rsp_if.sv */
interface sse_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] bus_byte;
	logic       start_before;
	logic       stop_after;
	logic       last;

	modport source (
		output valid, bus_byte, start_before, stop_after, last,
		input  ready
	);
	modport sink (
		input  valid, bus_byte, start_before, stop_after, last,
		output ready
	);
endinterface

/* rtl/sse_cfg_if.sv */
interface sse_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] brightness;

	modport source (
		output valid, brightness,
		input  ready
	);
	modport sink (
		input  valid, brightness,
		output ready
	);
endinterface

/* rtl/seven_segment_frame_encoder.sv */
// Turns one display request (a 16-bit number or four ASCII characters) into the
// seven command bytes for a four-digit segment display controller: data-write
// 0x40, address 0xC0, the four segment bytes leftmost first, then display-on
// 0x88 with the brightness level. A number shows its low four decimal digits
// with leading zeros; any character outside '0'..'9' shows blank. Requests pass
// a four-stage digit pipeline (one decimal digit per stage) and then a byte
// serializer, which sends one byte per cycle while the receiver is ready; a new
// request enters the pipeline while bytes of the previous one are still going
// out. Brightness is sampled when the display-on byte goes out and should be
// written only while the block is idle.
module seven_segment_frame_encoder (
	input  logic      clk,
	input  logic      arst_n,
	sse_cfg_if.sink   cfg,
	sse_req_if.sink   req,
	sse_rsp_if.source rsp
);
	import sse_pkg::*;

	logic [2:0] brightness_q;

	logic  valid_c [DIGIT_COUNT+1];
	logic  ready_c [DIGIT_COUNT+1];
	work_t work_c  [DIGIT_COUNT+1];

	// Configuration is always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHT_RESET;
		end else if (cfg.valid) begin
			brightness_q <= cfg.brightness;
		end
	end

	// Pack the request into pipeline work; positions past the fourth are blank
	always_comb begin
		work_c[0].cmd   = req.cmd;
		work_c[0].quot  = req.number;
		work_c[0].segs  = '0;
		work_c[0].chars = '0;
		work_c[0].chars[POS_W'(0)] = req.char_first;
		if (DIGIT_COUNT > 1) work_c[0].chars[POS_W'(1)] = req.char_second;
		if (DIGIT_COUNT > 2) work_c[0].chars[POS_W'(2)] = req.char_third;
		if (DIGIT_COUNT > 3) work_c[0].chars[POS_W'(3)] = req.char_fourth;
	end

	assign valid_c[0] = req.valid;
	assign req.ready  = ready_c[0];

	// One stage per digit, rightmost digit first
	for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_stage
		sse_digit_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.pos       (POS_W'(DIGIT_COUNT - 1 - i)),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_work   (work_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_work  (work_c[i+1])
		);
	end

	sse_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.brightness (brightness_q),
		.in_valid   (valid_c[DIGIT_COUNT]),
		.in_ready   (ready_c[DIGIT_COUNT]),
		.in_segs    (work_c[DIGIT_COUNT].segs),
		.rsp        (rsp)
	);

endmodule

/* rtl/sse_digit_stage.sv */
module sse_digit_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  sse_pkg::pos_t  pos,
	input  logic           in_valid,
	output logic           in_ready,
	input  sse_pkg::work_t in_work,
	output logic           out_valid,
	input  logic           out_ready,
	output sse_pkg::work_t out_work
);
	import sse_pkg::*;

	logic        valid_s1;
	work_t       work_s1;
	work_t       work_nxt;
	logic [15:0] quot_nxt;
	logic [15:0] rem_full;

	// Take a beat when empty or when the next stage drains this one
	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_work  = work_s1;

	// Split off one decimal digit and fill this stage's segment position
	always_comb begin
		quot_nxt = div10(in_work.quot);
		rem_full = in_work.quot - ((quot_nxt << 3) + (quot_nxt << 1));
		work_nxt = in_work;
		work_nxt.quot = quot_nxt;
		if (in_work.cmd == REQ_CHARS) begin
			work_nxt.segs[pos] = seg_of_char(in_work.chars[pos]);
		end else begin
			work_nxt.segs[pos] = seg_of_digit(rem_full[3:0]);
		end
	end

	// Advance the valid bit whenever the stage may move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload unless a new beat comes in
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			work_s1 <= work_nxt;
		end
	end

endmodule

/* rtl/sse_serializer.sv */
module sse_serializer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [2:0]                            brightness,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [sse_pkg::DIGIT_COUNT-1:0][7:0]  in_segs,
	sse_rsp_if.source                             rsp
);
	import sse_pkg::*;

	logic                        valid_q;
	beat_t                       beat_q;
	logic [DIGIT_COUNT-1:0][7:0] segs_q;
	logic                        final_beat;
	pos_t                        seg_idx;

	assign final_beat = (beat_q == BEAT_CTRL_CMD);
	assign in_ready   = !valid_q || (rsp.ready && final_beat);
	assign seg_idx    = POS_W'(beat_q - BEAT_SEG_FIRST);

	// Drive the current beat of the frame sequence
	always_comb begin
		rsp.valid        = valid_q;
		rsp.bus_byte     = segs_q[seg_idx];
		rsp.start_before = 1'b0;
		rsp.stop_after   = 1'b0;
		rsp.last         = 1'b0;
		if (beat_q == BEAT_DATA_CMD) begin
			rsp.bus_byte     = CMD_DATA_WRITE;
			rsp.start_before = 1'b1;
			rsp.stop_after   = 1'b1;
		end else if (beat_q == BEAT_ADDR_CMD) begin
			rsp.bus_byte     = CMD_ADDRESS;
			rsp.start_before = 1'b1;
		end else if (final_beat) begin
			rsp.bus_byte     = CMD_DISPLAY_ON | {5'b0, brightness};
			rsp.start_before = 1'b1;
			rsp.stop_after   = 1'b1;
			rsp.last         = 1'b1;
		end else if (beat_q == BEAT_SEG_LAST) begin
			rsp.stop_after   = 1'b1;
		end
	end

	// Step through the beats; load the next request as the last one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= BEAT_DATA_CMD;
		end else if (in_ready) begin
			valid_q <= in_valid;
			beat_q  <= BEAT_DATA_CMD;
		end else if (rsp.ready) begin
			beat_q  <= beat_q + BEAT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			segs_q <= in_segs;
		end
	end

endmodule
